// File: design/fbcm_pkg.sv
// Package for the fixed block content matcher.
// Holds sizes, stream widths, the cell control and token structs, and the
// sequencer state type. Depends on nothing.
package fbcm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int BLOCK_BYTES = 4;
	localparam int ID_WIDTH    = 32;

	localparam int BLOCK_W    = 8 * BLOCK_BYTES;
	localparam int PART_W     = 8 * (BLOCK_BYTES - 1);
	localparam int FILL_W     = $clog2(BLOCK_BYTES);
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int IN_DATA_W  = ((8 + ID_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ID_WIDTH + 1 + 7) / 8) * 8;

	// Input kinds carried on tuser.
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_SCAN  = 1'b1;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic wr_en;    // a complete store block is offered to the row
		logic scan_en;  // the scan window is full and is compared this cycle
		logic clr_hits; // the result was taken, so all hit flags are dropped
		logic search;   // the priority token moves one cell further
	} cell_ctl_t;

	// Priority token that walks the row from the lowest cell upward.
	typedef struct packed {
		logic                found;
		logic [ID_WIDTH-1:0] id;
	} token_t;

	typedef enum logic {
		ST_STREAM,
		ST_RESOLVE
	} fbcm_state_t;

endpackage

// File: design/fbcm_cell.sv
// One table cell: a stored block, its region id, a used bit and a hit flag.
// Passes the used bit and the priority token to its upper neighbor.
// Depends on fbcm_pkg.
module fbcm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbcm_pkg::cell_ctl_t           ctl,
	input  logic [fbcm_pkg::BLOCK_W-1:0]  window,
	input  logic [fbcm_pkg::BLOCK_W-1:0]  wr_block,
	input  logic [fbcm_pkg::ID_WIDTH-1:0] wr_id,
	input  logic                          prev_used,
	input  fbcm_pkg::token_t              tok_in,
	output logic                          used,
	output fbcm_pkg::token_t              tok_out
);

	logic                          used_q;
	logic                          hit_q;
	logic [fbcm_pkg::BLOCK_W-1:0]  pat_q;
	logic [fbcm_pkg::ID_WIDTH-1:0] own_q;
	fbcm_pkg::token_t              tok_q;
	logic                          take;

	// The lowest free cell takes a new block.
	assign take = ctl.wr_en && prev_used && !used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (take) begin
				used_q <= 1'b1;
			end
			if (ctl.clr_hits) begin
				hit_q <= 1'b0;
			end else if (ctl.scan_en && used_q && (pat_q == window)) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pat_q <= wr_block;
			own_q <= wr_id;
		end
		if (ctl.search) begin
			if (!tok_in.found && hit_q) begin
				tok_q <= '{found: 1'b1, id: own_q};
			end else begin
				tok_q <= tok_in;
			end
		end
	end

	assign used    = used_q;
	assign tok_out = tok_q;

endmodule

// File: design/fbcm_row.sv
// Row of table cells chained in storage order.
// Reports when the table is full and the token leaving the last cell.
// Depends on fbcm_pkg and fbcm_cell.
module fbcm_row (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbcm_pkg::cell_ctl_t           ctl,
	input  logic [fbcm_pkg::BLOCK_W-1:0]  window,
	input  logic [fbcm_pkg::BLOCK_W-1:0]  wr_block,
	input  logic [fbcm_pkg::ID_WIDTH-1:0] wr_id,
	output logic                          full,
	output fbcm_pkg::token_t              result
);

	logic             used_chain [fbcm_pkg::TABLE_DEPTH+1];
	fbcm_pkg::token_t tok_chain  [fbcm_pkg::TABLE_DEPTH+1];

	assign used_chain[0] = 1'b1;
	assign tok_chain[0]  = '{found: 1'b0, id: '0};

	for (genvar i = 0; i < fbcm_pkg::TABLE_DEPTH; i++) begin : g_cell
		fbcm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.window    (window),
			.wr_block  (wr_block),
			.wr_id     (wr_id),
			.prev_used (used_chain[i]),
			.tok_in    (tok_chain[i]),
			.used      (used_chain[i+1]),
			.tok_out   (tok_chain[i+1])
		);
	end

	assign full   = used_chain[fbcm_pkg::TABLE_DEPTH];
	assign result = tok_chain[fbcm_pkg::TABLE_DEPTH];

endmodule

// File: design/fixed_block_content_matcher_unit.sv
// Fixed block content matcher, top level: byte stream in, one result per scan buffer out.
// Throughput is one byte per cycle for store bytes and for scan bytes that are not last.
// After the last byte of a scan buffer the input stalls while a priority token walks the
// TABLE_DEPTH cells, longer while an earlier result still waits; the result is loaded
// once the output register is free. Reset (arst_n low) empties the table and clears the
// hit, overflow and output valid flags. Needs fbcm_row.
module fixed_block_content_matcher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [fbcm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // data_byte, region_id, zero pad
	input  logic                            s_axis_tuser,  // cmd
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fbcm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // matched_id, blocks_dropped, pad
	output logic                            m_axis_tuser   // found
);

	// Input unpacking.
	logic [7:0]                    data_byte;
	logic [fbcm_pkg::ID_WIDTH-1:0] region_id;
	logic                          in_xfer;
	logic                          store_xfer;
	logic                          scan_xfer;

	assign data_byte  = s_axis_tdata[7:0];
	assign region_id  = s_axis_tdata[8 +: fbcm_pkg::ID_WIDTH];
	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign store_xfer = in_xfer && (s_axis_tuser == fbcm_pkg::CMD_STORE);
	assign scan_xfer  = in_xfer && (s_axis_tuser == fbcm_pkg::CMD_SCAN);

	// Store side: bytes gather into aligned blocks. The byte that completes a
	// block brings the region id, and a trailing partial block is simply dropped
	// when the buffer ends.
	logic [fbcm_pkg::PART_W-1:0]  store_partial_q;
	logic [fbcm_pkg::FILL_W-1:0]  store_fill_q;
	logic                         store_full;
	logic [fbcm_pkg::BLOCK_W-1:0] store_block;
	logic                         overflow_q;
	logic                         table_full;

	assign store_full  = (store_fill_q == fbcm_pkg::FILL_W'(fbcm_pkg::BLOCK_BYTES - 1));
	assign store_block = {store_partial_q, data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_partial_q <= '0;
			store_fill_q    <= '0;
			overflow_q      <= 1'b0;
		end else if (store_xfer) begin
			if (store_full || s_axis_tlast) begin
				store_partial_q <= '0;
				store_fill_q    <= '0;
			end else begin
				store_partial_q <= fbcm_pkg::PART_W'(store_block);
				store_fill_q    <= store_fill_q + 1'b1;
			end
			// With the table full a completed block is lost; the flag is sticky.
			if (store_full && table_full) begin
				overflow_q <= 1'b1;
			end
		end
	end

	// Scan side: a sliding window of the newest bytes. Comparison starts once
	// the window holds a full block, so short buffers never match.
	logic [fbcm_pkg::PART_W-1:0]  scan_window_q;
	logic [fbcm_pkg::FILL_W-1:0]  scan_fill_q;
	logic                         scan_full;
	logic [fbcm_pkg::BLOCK_W-1:0] scan_block;

	assign scan_full  = (scan_fill_q == fbcm_pkg::FILL_W'(fbcm_pkg::BLOCK_BYTES - 1));
	assign scan_block = {scan_window_q, data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_window_q <= '0;
			scan_fill_q   <= '0;
		end else if (scan_xfer) begin
			if (s_axis_tlast) begin
				scan_window_q <= '0;
				scan_fill_q   <= '0;
			end else begin
				scan_window_q <= fbcm_pkg::PART_W'(scan_block);
				if (!scan_full) begin
					scan_fill_q <= scan_fill_q + 1'b1;
				end
			end
		end
	end

	// Sequencer. In ST_STREAM bytes flow freely. The last scan byte moves it
	// to ST_RESOLVE, where the token walks the row one cell per cycle; when it
	// has left the last cell and the output register is free, the result is
	// loaded and all hit flags are cleared in the same cycle.
	fbcm_pkg::fbcm_state_t        state_q;
	fbcm_pkg::fbcm_state_t        state_d;
	logic [fbcm_pkg::CNT_W-1:0]   search_cnt_q;
	logic                         search_done;
	logic                         out_free;
	logic                         load_result;
	fbcm_pkg::cell_ctl_t          ctl;
	fbcm_pkg::token_t             result;

	assign search_done = (search_cnt_q == fbcm_pkg::CNT_W'(fbcm_pkg::TABLE_DEPTH));
	assign out_free    = !m_axis_tvalid || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbcm_pkg::ST_STREAM: begin
				if (scan_xfer && s_axis_tlast) begin
					state_d = fbcm_pkg::ST_RESOLVE;
				end
			end
			fbcm_pkg::ST_RESOLVE: begin
				if (search_done && out_free) begin
					state_d = fbcm_pkg::ST_STREAM;
				end
			end
			default: state_d = fbcm_pkg::ST_STREAM;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		load_result   = 1'b0;
		ctl           = '0;
		unique case (state_q)
			fbcm_pkg::ST_STREAM: begin
				s_axis_tready = 1'b1;
				ctl.wr_en     = store_xfer && store_full;
				ctl.scan_en   = scan_xfer && scan_full;
			end
			fbcm_pkg::ST_RESOLVE: begin
				ctl.search    = !search_done;
				load_result   = search_done && out_free;
				ctl.clr_hits  = load_result;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbcm_pkg::ST_STREAM;
			search_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fbcm_pkg::ST_STREAM) begin
				search_cnt_q <= '0;
			end else if (!search_done) begin
				search_cnt_q <= search_cnt_q + 1'b1;
			end
		end
	end

	// The table: one cell per entry, filled in order, compared in parallel.
	fbcm_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.window   (scan_block),
		.wr_block (store_block),
		.wr_id    (region_id),
		.full     (table_full),
		.result   (result)
	);

	// Output register. The input side keeps streaming while a result waits.
	logic                          out_valid_q;
	logic                          out_found_q;
	logic [fbcm_pkg::ID_WIDTH-1:0] out_id_q;
	logic                          out_dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			out_found_q   <= result.found;
			out_id_q      <= result.found ? result.id : '0;
			out_dropped_q <= overflow_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = fbcm_pkg::OUT_DATA_W'({out_dropped_q, out_id_q});

endmodule

// File: design/fbcm_checker.sv
// Port-level checker for the fixed block content matcher, bound to the top level.
// Depends on fbcm_pkg and fixed_block_content_matcher_unit.
module fbcm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tuser,
	input logic                            s_axis_tlast,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [fbcm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser
);

	// The end of a scan buffer always stalls the input while the table resolves.
	a_scan_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tuser == fbcm_pkg::CMD_SCAN)
		|=> !s_axis_tready)
		else $error("input not stalled after the last scan byte");

	// A new result only appears at the end of a stall.
	a_result_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a resolve phase");

	// A miss reports a zero region id.
	a_miss_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[fbcm_pkg::ID_WIDTH-1:0] == '0))
		else $error("miss with a nonzero region id");

	// A stalled result transfer holds its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

endmodule

bind fixed_block_content_matcher_unit fbcm_checker u_fbcm_checker (.*);

// File: verif/tb_fixed_block_content_matcher_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_content_matcher_unit: directed rows, then random
// store and scan buffers, each result checked against a behavioral predictor or a typed row's verdict.
// Depends on fbcm_pkg and the matcher RTL.
module tb_fixed_block_content_matcher_unit;

	localparam int ITEMS_TARGET   = 1550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_BUF        = 16;

	// One input byte with its tags.
	typedef struct packed {
		logic                          cmd;
		logic [7:0]                    data_byte;
		logic [fbcm_pkg::ID_WIDTH-1:0] region_id;
		logic                          last;
	} byte_xfer_t;

	// Outcome of one scan buffer.
	typedef struct packed {
		logic                          found;
		logic [fbcm_pkg::ID_WIDTH-1:0] matched_id;
		logic                          blocks_dropped;
	} scan_verdict_t;

	typedef struct {
		byte_xfer_t    x;
		bit            typed;
		scan_verdict_t v;
	} stim_row_t;

	localparam scan_verdict_t NO_HIT = '0;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [fbcm_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // data_byte, region_id, zero pad
	logic                            s_axis_tuser  = 1'b0; // cmd
	logic                            s_axis_tlast  = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [fbcm_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // matched_id, blocks_dropped, pad
	logic                            m_axis_tuser;  // found

	fixed_block_content_matcher_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Shadow of the block table and the two byte paths.
	logic [fbcm_pkg::BLOCK_W-1:0]     tbl_blk [fbcm_pkg::TABLE_DEPTH];
	logic [fbcm_pkg::ID_WIDTH-1:0]    tbl_own [fbcm_pkg::TABLE_DEPTH];
	int                               n_used;
	logic [fbcm_pkg::PART_W-1:0]      st_part;
	int                               st_fill;
	logic [fbcm_pkg::PART_W-1:0]      sc_win;
	int                               sc_fill;
	logic [fbcm_pkg::TABLE_DEPTH-1:0] hits;
	logic                             dropped;

	scan_verdict_t verdict_q[$];
	stim_row_t     dir_rows[$];
	int            n_sent = 0;
	int            n_errors = 0;
	bit            calm = 1'b0; // no random idling on either side while set

	// Advances the shadow state by one accepted byte; returns 1 when a result is due.
	function automatic bit predict_verdict(input byte_xfer_t x, output scan_verdict_t v);
		logic [fbcm_pkg::BLOCK_W-1:0] blk;
		v = NO_HIT;
		if (x.cmd == fbcm_pkg::CMD_STORE) begin
			if (st_fill >= fbcm_pkg::BLOCK_BYTES - 1) begin
				blk = {st_part, x.data_byte};
				if (n_used < fbcm_pkg::TABLE_DEPTH) begin
					tbl_blk[n_used] = blk;
					tbl_own[n_used] = x.region_id;
					n_used++;
				end else begin
					dropped = 1'b1;
				end
				st_part = '0;
				st_fill = 0;
			end else begin
				st_part = fbcm_pkg::PART_W'({st_part, x.data_byte});
				st_fill++;
			end
			if (x.last) begin
				st_part = '0;
				st_fill = 0;
			end
			return 1'b0;
		end
		if (sc_fill >= fbcm_pkg::BLOCK_BYTES - 1) begin
			blk = {sc_win, x.data_byte};
			for (int i = 0; i < n_used; i++)
				if (tbl_blk[i] == blk)
					hits[i] = 1'b1;
		end else begin
			sc_fill++;
		end
		sc_win = fbcm_pkg::PART_W'({sc_win, x.data_byte});
		if (!x.last)
			return 1'b0;
		// The lowest set flag names the earliest stored block, so scan downward.
		for (int i = fbcm_pkg::TABLE_DEPTH - 1; i >= 0; i--)
			if (hits[i]) begin
				v.found      = 1'b1;
				v.matched_id = tbl_own[i];
			end
		v.blocks_dropped = dropped;
		hits    = '0;
		sc_win  = '0;
		sc_fill = 0;
		return 1'b1;
	endfunction

	function automatic void add_row(input logic cmd, input logic [7:0] b,
			input logic [fbcm_pkg::ID_WIDTH-1:0] id, input logic last,
			input bit typed = 1'b0, input scan_verdict_t v = NO_HIT);
		stim_row_t r;
		r.x     = '{cmd: cmd, data_byte: b, region_id: id, last: last};
		r.typed = typed;
		r.v     = v;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Narrow alphabet makes chance matches across buffers likely.
	function automatic logic [7:0] pick_byte(input bit narrow);
		if (!narrow)
			return 8'($urandom_range(255));
		case ($urandom_range(2))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'hA5;
		endcase
	endfunction

	function automatic logic [fbcm_pkg::ID_WIDTH-1:0] pick_id();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return fbcm_pkg::ID_WIDTH'($urandom);
		endcase
	endfunction

	// Offers one byte, waits for the transfer, then predicts what it causes. A typed row
	// overrides the predicted result with the verdict given in the row.
	task automatic push_transfer(input byte_xfer_t x, input bit typed = 1'b0,
			input scan_verdict_t tv = NO_HIT);
		logic [fbcm_pkg::IN_DATA_W-1:0] word;
		scan_verdict_t                  v;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		word = '0;
		word[7:0] = x.data_byte;
		word[8 +: fbcm_pkg::ID_WIDTH] = x.region_id;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= x.cmd;
		s_axis_tlast  <= x.last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (predict_verdict(x, v))
			verdict_q.insert(verdict_q.size(), typed ? tv : v);
		n_sent++;
		calm = (n_sent >= 700 && n_sent < 1000);
	endtask

	// Result side stalls at random, except during the calm stretch.
	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 29);

	// Result checker and watchdog. Sampled at the rising edge, before the block updates.
	int idle_cycles = 0;
	always @(posedge clk) begin : result_check
		scan_verdict_t act;
		scan_verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act.found          = m_axis_tuser;
			act.matched_id     = m_axis_tdata[fbcm_pkg::ID_WIDTH-1:0];
			act.blocks_dropped = m_axis_tdata[fbcm_pkg::ID_WIDTH];
			if (verdict_q.size() == 0) begin
				$error("result with no scan buffer pending: found %0d id %h",
					act.found, act.matched_id);
				n_errors++;
			end else begin
				want = verdict_q.pop_front();
				if (act.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, act.found);
					n_errors++;
				end
				if (act.matched_id !== want.matched_id) begin
					$error("matched_id: expected %h, actual %h",
						want.matched_id, act.matched_id);
					n_errors++;
				end
				if (act.blocks_dropped !== want.blocks_dropped) begin
					$error("blocks_dropped: expected %0d, actual %0d",
						want.blocks_dropped, act.blocks_dropped);
					n_errors++;
				end
			end
		end
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		byte_xfer_t                    x;
		logic [7:0]                    bytes [MAX_BUF];
		int                            len;
		int                            kind;
		int                            n_buf;
		int                            off;
		int                            idx;
		bit                            narrow;
		logic [fbcm_pkg::ID_WIDTH-1:0] buf_id;

		n_used  = 0;
		st_part = '0;
		st_fill = 0;
		sc_win  = '0;
		sc_fill = 0;
		hits    = '0;
		dropped = 1'b0;

		// Directed rows. Empty table: short and full-length scans find nothing.
		add_row(fbcm_pkg::CMD_SCAN, 8'h41, '0, 1'b1, 1'b1, NO_HIT);
		add_row(fbcm_pkg::CMD_SCAN, 8'h00, '0, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hFF, '0, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'h00, '0, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hFF, '1, 1'b1, 1'b1, NO_HIT);
		// A block takes the id that comes with its completing byte.
		add_row(fbcm_pkg::CMD_STORE, 8'hDE, '0, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'hAD, '0, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'hBE, '0, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'hEF, '1, 1'b1);
		// A short store buffer leaves nothing behind.
		add_row(fbcm_pkg::CMD_STORE, 8'h00, '1, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'h00, '1, 1'b1);
		add_row(fbcm_pkg::CMD_STORE, 8'hFF, '1, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'hFF, '1, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'hFF, '1, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'hFF, '0, 1'b1);
		// Scan with a store byte in the middle of it; the window must not be disturbed.
		add_row(fbcm_pkg::CMD_SCAN, 8'h12, '0, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hDE, '0, 1'b0);
		add_row(fbcm_pkg::CMD_STORE, 8'h55, '1, 1'b1);
		add_row(fbcm_pkg::CMD_SCAN, 8'hAD, '0, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hBE, '0, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hEF, '0, 1'b1, 1'b1,
			'{found: 1'b1, matched_id: '1, blocks_dropped: 1'b0});
		add_row(fbcm_pkg::CMD_SCAN, 8'hFF, '1, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hFF, '1, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hFF, '1, 1'b0);
		add_row(fbcm_pkg::CMD_SCAN, 8'hFF, '1, 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			push_transfer(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].v);

		// Random buffers. Most are well formed; scans usually carry stored blocks so that
		// hits, priority between duplicates, and the full table all get exercised.
		n_buf = 0;
		while (n_sent < ITEMS_TARGET) begin
			n_buf++;
			if (n_buf % 25 == 0) begin
				// Hold the input until every pending result has drained.
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (verdict_q.size() != 0)
					@(negedge clk);
			end
			kind   = $urandom_range(99);
			narrow = ($urandom_range(3) == 0);
			if (kind < 40) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
				for (int k = 0; k < len; k++)
					bytes[k] = pick_byte(narrow);
				// Sometimes store a copy of an existing block under a new id.
				if (len >= fbcm_pkg::BLOCK_BYTES && n_used > 0 && $urandom_range(3) == 0) begin
					idx = $urandom_range(n_used - 1);
					for (int k = 0; k < fbcm_pkg::BLOCK_BYTES; k++)
						bytes[k] = tbl_blk[idx][fbcm_pkg::BLOCK_W-1-8*k -: 8];
				end
				buf_id = pick_id();
				for (int k = 0; k < len; k++) begin
					x.cmd       = fbcm_pkg::CMD_STORE;
					x.data_byte = bytes[k];
					x.region_id = ($urandom_range(4) == 0) ? pick_id() : buf_id;
					x.last      = (k == len - 1);
					push_transfer(x);
				end
			end else if (kind < 88) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, MAX_BUF);
				for (int k = 0; k < len; k++)
					bytes[k] = pick_byte(narrow);
				if (len >= fbcm_pkg::BLOCK_BYTES && n_used > 0 && $urandom_range(9) < 7) begin
					repeat ($urandom_range(1, 2)) begin
						idx = $urandom_range(n_used - 1);
						off = $urandom_range(len - fbcm_pkg::BLOCK_BYTES);
						for (int k = 0; k < fbcm_pkg::BLOCK_BYTES; k++)
							bytes[off + k] = tbl_blk[idx][fbcm_pkg::BLOCK_W-1-8*k -: 8];
					end
				end
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(99) < 8) begin
						x.cmd       = fbcm_pkg::CMD_STORE;
						x.data_byte = pick_byte(narrow);
						x.region_id = pick_id();
						x.last      = ($urandom_range(4) == 0);
						push_transfer(x);
					end
					x.cmd       = fbcm_pkg::CMD_SCAN;
					x.data_byte = bytes[k];
					x.region_id = fbcm_pkg::ID_WIDTH'($urandom);
					x.last      = (k == len - 1);
					push_transfer(x);
				end
			end else begin
				x.cmd       = 1'($urandom_range(1));
				x.data_byte = 8'($urandom_range(255));
				x.region_id = fbcm_pkg::ID_WIDTH'($urandom);
				x.last      = 1'($urandom_range(1));
				push_transfer(x);
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (2 * fbcm_pkg::TABLE_DEPTH + 8) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
design/fbcm_pkg.sv
design/fbcm_cell.sv
design/fbcm_row.sv
design/fixed_block_content_matcher_unit.sv
design/fbcm_checker.sv
verif/tb_fixed_block_content_matcher_unit.sv
